// ----- rtl/ecd_pkg.sv -----
// Shared types, constants and calendar helper functions for the epoch to date converter.
package ecd_pkg;

	localparam int unsigned EcdAluWidth = 32;

	localparam logic [31:0] ECD_SEC_PER_MIN         = 32'd60;
	localparam logic [31:0] ECD_SEC_PER_HOUR        = 32'd3600;
	localparam logic [31:0] ECD_SEC_PER_DAY         = 32'd86400;
	localparam logic [31:0] ECD_SEC_PER_MONTH_28    = 32'd2419200;
	localparam logic [31:0] ECD_SEC_PER_MONTH_29    = 32'd2505600;
	localparam logic [31:0] ECD_SEC_PER_MONTH_30    = 32'd2592000;
	localparam logic [31:0] ECD_SEC_PER_MONTH_31    = 32'd2678400;
	localparam logic [31:0] ECD_SEC_PER_COMMON_YEAR = 32'd31536000;
	localparam logic [31:0] ECD_SEC_PER_LEAP_YEAR   = 32'd31622400;
	localparam logic [11:0] ECD_EPOCH_YEAR   = 12'd1970;
	// The only century year in the reachable range (1970..2106) that is not a leap year.
	localparam logic [11:0] ECD_SKIP_CENTURY = 12'd2100;
	localparam logic [3:0]  ECD_LAST_MONTH   = 4'd11;

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic [19:0] microseconds;
	} ecd_in_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month_index;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [19:0] microseconds_out;
	} ecd_out_t;

	// Gregorian rule reduced to the years this block can reach.
	function automatic logic ecd_is_leap(input logic [11:0] year);
		ecd_is_leap = (year[1:0] == 2'b00) && (year != ECD_SKIP_CENTURY);
	endfunction

	// Length of a month in seconds.
	function automatic logic [31:0] ecd_month_secs(input logic leap, input logic [3:0] month);
		unique case (month)
			4'd1:                      ecd_month_secs = leap ? ECD_SEC_PER_MONTH_29
			                                                 : ECD_SEC_PER_MONTH_28;
			4'd3, 4'd5, 4'd8, 4'd10:   ecd_month_secs = ECD_SEC_PER_MONTH_30;
			default:                   ecd_month_secs = ECD_SEC_PER_MONTH_31;
		endcase
	endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar_date_unit.sv -----
// Top level: converts seconds since 1970-01-01 UTC into calendar date and time of day.
// Busy stays high from the accepting edge until the minute walk ends. The result strobe is
// registered from the core's done flag, which rises as busy falls, through the output valid
// register. The next transaction may be accepted at the first edge with busy low. Reset
// clears sequencer and strobe.
module epoch_seconds_to_calendar_date_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ecd_pkg::ecd_in_t  item,
	output logic              busy,
	output logic              result_valid,
	output ecd_pkg::ecd_out_t result
);

	logic              core_busy;
	logic              core_done;
	ecd_pkg::ecd_out_t core_result;
	logic              valid_q;
	ecd_pkg::ecd_out_t result_q;

	// The core does the whole conversion on one shared subtract and compare unit. Each step
	// tries to take one year, month, day, hour or minute, in seconds, off the count; each walk
	// takes one step per whole span it removes plus one step that finds the span too long.
	ecd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (start && !core_busy),
		.item   (item),
		.busy   (core_busy),
		.done   (core_done),
		.result (core_result)
	);

	// The output register frees the core as soon as its last step completes, so the next
	// transaction can begin while this result is on the ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= core_done;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			result_q <= core_result;
		end
	end

	assign busy         = core_busy;
	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/ecd_alu.sv -----
// Shared subtract and compare unit used by every step of the converter.
module ecd_alu (
	input  logic [ecd_pkg::EcdAluWidth-1:0] op_a,
	input  logic [ecd_pkg::EcdAluWidth-1:0] op_b,
	output logic [ecd_pkg::EcdAluWidth-1:0] diff,
	output logic                            ge
);

	logic [ecd_pkg::EcdAluWidth:0] wide_diff;

	// The borrow out of the subtraction doubles as the compare result.
	assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
	assign diff      = wide_diff[ecd_pkg::EcdAluWidth-1:0];
	assign ge        = ~wide_diff[ecd_pkg::EcdAluWidth];

endmodule

// ----- rtl/ecd_core.sv -----
// Sequencer that drives the shared unit through the year, month, day, hour and minute walks.
module ecd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ecd_pkg::ecd_in_t item,
	output logic             busy,
	output logic             done,
	output ecd_pkg::ecd_out_t result
);

	typedef enum logic [2:0] {
		IDLE,
		YEAR_WALK,
		MONTH_WALK,
		DAY_WALK,
		HOUR_WALK,
		MIN_WALK
	} state_t;

	state_t      state_q;
	logic        done_q;
	logic [31:0] rem_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [19:0] usec_q;

	logic [31:0] op_b;
	logic [31:0] diff;
	logic        ge;
	logic        leap;

	ecd_alu u_alu (
		.op_a (rem_q),
		.op_b (op_b),
		.diff (diff),
		.ge   (ge)
	);

	assign leap = ecd_pkg::ecd_is_leap(year_q);

	// Every step tries to take one whole span, in seconds, off what is left of the count.
	always_comb begin
		unique case (state_q)
			YEAR_WALK: begin
				op_b = leap ? ecd_pkg::ECD_SEC_PER_LEAP_YEAR : ecd_pkg::ECD_SEC_PER_COMMON_YEAR;
			end
			MONTH_WALK: begin
				op_b = ecd_pkg::ecd_month_secs(leap, month_q);
			end
			DAY_WALK: begin
				op_b = ecd_pkg::ECD_SEC_PER_DAY;
			end
			HOUR_WALK: begin
				op_b = ecd_pkg::ECD_SEC_PER_HOUR;
			end
			MIN_WALK: begin
				op_b = ecd_pkg::ECD_SEC_PER_MIN;
			end
			default: begin
				op_b = ecd_pkg::ECD_SEC_PER_DAY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (load) begin
						state_q <= YEAR_WALK;
					end
				end
				YEAR_WALK: begin
					if (!ge) begin
						state_q <= MONTH_WALK;
					end
				end
				MONTH_WALK: begin
					if (!ge || (month_q == ecd_pkg::ECD_LAST_MONTH)) begin
						state_q <= DAY_WALK;
					end
				end
				DAY_WALK: begin
					if (!ge) begin
						state_q <= HOUR_WALK;
					end
				end
				HOUR_WALK: begin
					if (!ge) begin
						state_q <= MIN_WALK;
					end
				end
				MIN_WALK: begin
					if (!ge) begin
						state_q <= IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IDLE: begin
				if (load) begin
					rem_q   <= item.epoch_seconds;
					usec_q  <= item.microseconds;
					year_q  <= ecd_pkg::ECD_EPOCH_YEAR;
					month_q <= '0;
					day_q   <= '0;
					hour_q  <= '0;
					min_q   <= '0;
				end
			end
			YEAR_WALK: begin
				if (ge) begin
					rem_q  <= diff;
					year_q <= year_q + 12'd1;
				end
			end
			MONTH_WALK: begin
				if (ge && (month_q != ecd_pkg::ECD_LAST_MONTH)) begin
					rem_q   <= diff;
					month_q <= month_q + 4'd1;
				end
			end
			DAY_WALK: begin
				if (ge) begin
					rem_q <= diff;
					day_q <= day_q + 5'd1;
				end
			end
			HOUR_WALK: begin
				if (ge) begin
					rem_q  <= diff;
					hour_q <= hour_q + 5'd1;
				end
			end
			MIN_WALK: begin
				if (ge) begin
					rem_q <= diff;
					min_q <= min_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != IDLE);
	assign done = done_q;

	// What is left after the minute walk is the second of the minute.
	always_comb begin
		result.year             = year_q;
		result.month_index      = month_q;
		result.day_of_month     = day_q + 5'd1;
		result.hour             = hour_q;
		result.minute           = min_q;
		result.second           = rem_q[5:0];
		result.microseconds_out = usec_q;
	end

endmodule

// ----- rtl/ecd_checker.sv -----
// Port level checker for the epoch to date converter, bound to the top level.
module ecd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input ecd_pkg::ecd_out_t result
);

	// An accepted transaction must make the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Every completed conversion shows its result right after busy drops.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |=> result_valid)
		else $error("missing result strobe after conversion");

	// A strobe only follows a cycle in which the block was idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(busy))
		else $error("result strobe while conversion still running");

	// Results stay within the calendar ranges.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.month_index <= 4'd11) && (result.day_of_month != 5'd0)
			&& (result.hour <= 5'd23) && (result.minute <= 6'd59)
			&& (result.second <= 6'd59) && (result.year >= 12'd1970))
		else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_date_unit ecd_checker u_ecd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
